>>> src/sbd_pkg.sv
// Shared types, constants and register codes for the brush displacement block.
package sbd_pkg;

    localparam int MAX_GROUPS = 65536;
    localparam int CNT_FIELD_MAX = 131071;
    localparam logic [16:0] CNT_MAX =
        17'((MAX_GROUPS < CNT_FIELD_MAX) ? MAX_GROUPS : CNT_FIELD_MAX);
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [16:0] CULL_LIMIT = 17'd65;
    localparam int SQRT_STAGES = 31;
    localparam int DIV_STAGES = 16;
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_LINEAR  = 2'd0,
        MODE_CONST   = 2'd1,
        MODE_SMOOTH  = 2'd2,
        MODE_INFLATE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_MODE     = 3'd4,
        REG_OFFSET_X = 3'd5,
        REG_OFFSET_Y = 3'd6,
        REG_OFFSET_Z = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][31:0] center;
        logic [30:0]      radius;
        t_mode            mode;
        logic [2:0][31:0] offset;
    } t_cfg;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][15:0] nrm;
        logic             live;
        logic             pass_start;
    } t_ctx;

    typedef struct packed {
        t_ctx        ctx;
        logic [61:0] sq;
    } t_item;

endpackage

>>> src/sbd_front.sv
// Front end: accept items, measure distance to the brush centre and classify.
module sbd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sbd_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  sbd_pkg::t_ctx i_ctx,
    input  logic          i_full,
    output logic          o_push,
    output sbd_pkg::t_item o_item
);
    import sbd_pkg::*;

    logic en;
    logic r_v1, r_v2, r_v3;
    t_ctx r_ctx1, r_ctx2, r_ctx3;
    t_ctx n_ctx1, n_ctx3;
    logic [2:0][30:0] r_ad1;
    logic [2:0][61:0] r_sqr2;
    logic [61:0] r_rsq2, r_sq3;

    logic [2:0][32:0] d, ad;
    logic in_box, in_sphere;
    logic [63:0] s;

    assign en = !i_full;
    assign o_ready = en;

    always_comb begin
        in_box = i_ctx.live && (i_cfg.radius != 31'd0);
        for (int i = 0; i < 3; i++) begin
            d[i] = {i_ctx.pos[i][31], i_ctx.pos[i]} - {i_cfg.center[i][31], i_cfg.center[i]};
            ad[i] = d[i][32] ? 33'(-d[i]) : d[i];
            if (ad[i] >= {2'b00, i_cfg.radius}) begin
                in_box = 1'b0;
            end
        end
        s = {2'b00, r_sqr2[0]} + {2'b00, r_sqr2[1]} + {2'b00, r_sqr2[2]};
        in_sphere = r_ctx2.live && (s < {2'b00, r_rsq2});
        n_ctx1 = i_ctx;
        n_ctx1.live = in_box;
        n_ctx3 = r_ctx2;
        n_ctx3.live = in_sphere;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx1 <= n_ctx1;
            for (int i = 0; i < 3; i++) begin
                r_ad1[i] <= ad[i][30:0];
                r_sqr2[i] <= r_ad1[i] * r_ad1[i];
            end
            r_rsq2 <= i_cfg.radius * i_cfg.radius;
            r_ctx2 <= r_ctx1;
            r_ctx3 <= n_ctx3;
            r_sq3 <= in_sphere ? s[61:0] : 62'd0;
        end
    end

    assign o_push = r_v3 && en;
    assign o_item = '{ctx: r_ctx3, sq: r_sq3};

endmodule

>>> src/sbd_fifo.sv
// Short queue between the front end and the back end.
module sbd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sbd_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output sbd_pkg::t_item o_item
);
    import sbd_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    t_item mem [FIFO_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    logic do_pop;

    assign o_full = (r_cnt == (AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_pop = i_pop && !o_empty;
    assign o_item = mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(do_pop);
        end
    end

endmodule

>>> src/sbd_back.sv
// Back end: square root, ratio, falloff weight, displacement and affected count.
module sbd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sbd_pkg::t_cfg  i_cfg,
    input  logic           i_empty,
    input  sbd_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0][31:0] o_new,
    output logic           o_affected,
    output logic [16:0]    o_weight,
    output logic [16:0]    o_count
);
    import sbd_pkg::*;

    logic en;

    logic        r_sq_v    [SQRT_STAGES];
    t_ctx        r_sq_ctx  [SQRT_STAGES];
    logic [61:0] r_sq_s    [SQRT_STAGES];
    logic [32:0] r_sq_rem  [SQRT_STAGES];
    logic [30:0] r_sq_root [SQRT_STAGES];

    logic        in_sq_v    [SQRT_STAGES];
    t_ctx        in_sq_ctx  [SQRT_STAGES];
    logic [61:0] in_sq_s    [SQRT_STAGES];
    logic [32:0] in_sq_rem  [SQRT_STAGES];
    logic [30:0] in_sq_root [SQRT_STAGES];
    logic [32:0] n_sq_rem   [SQRT_STAGES];
    logic [30:0] n_sq_root  [SQRT_STAGES];
    logic [34:0] sq_cur     [SQRT_STAGES];
    logic [34:0] sq_test    [SQRT_STAGES];

    logic        r_dv_v   [DIV_STAGES];
    t_ctx        r_dv_ctx [DIV_STAGES];
    logic [30:0] r_dv_rem [DIV_STAGES];
    logic [15:0] r_dv_q   [DIV_STAGES];

    logic        in_dv_v   [DIV_STAGES];
    t_ctx        in_dv_ctx [DIV_STAGES];
    logic [30:0] in_dv_rem [DIV_STAGES];
    logic [15:0] in_dv_q   [DIV_STAGES];
    logic [30:0] n_dv_rem  [DIV_STAGES];
    logic [15:0] n_dv_q    [DIV_STAGES];
    logic [31:0] dv_tr     [DIV_STAGES];
    logic        dv_ge     [DIV_STAGES];

    logic r_w1_v, r_w2_v, r_w3_v, r_m1_v, r_m2_v;
    t_ctx r_w1_ctx, r_w2_ctx, r_w3_ctx, r_m1_ctx, r_m2_ctx;
    t_ctx n_w3_ctx;
    logic [15:0] r_w1_t, r_w2_t;
    logic [31:0] r_w1_t2, r_w2_t2;
    logic [47:0] r_w2_t3;
    logic [16:0] r_w3_w, r_m1_w, r_m2_w;
    logic signed [2:0][49:0] r_m1_mv, r_m2_mv;
    logic signed [2:0][65:0] r_m2_inf;

    logic [50:0] w_num;
    logic [16:0] w_raw;
    logic        w_hit;

    logic r_ov;
    logic [2:0][31:0] r_onew;
    logic r_oaff;
    logic [16:0] r_ow, r_cnt;

    logic signed [65:0] inf_r;
    logic signed [49:0] mv_r;
    logic signed [2:0][34:0] delta, sum;
    logic [2:0][31:0] res;
    logic [16:0] cnt_base, cnt_next;

    assign en = !r_ov || i_ready;
    assign o_pop = en;

    always_comb begin
        for (int j = 0; j < SQRT_STAGES; j++) begin
            if (j == 0) begin
                in_sq_v[j] = !i_empty;
                in_sq_ctx[j] = i_item.ctx;
                in_sq_s[j] = i_item.sq;
                in_sq_rem[j] = '0;
                in_sq_root[j] = '0;
            end else begin
                in_sq_v[j] = r_sq_v[j-1];
                in_sq_ctx[j] = r_sq_ctx[j-1];
                in_sq_s[j] = r_sq_s[j-1];
                in_sq_rem[j] = r_sq_rem[j-1];
                in_sq_root[j] = r_sq_root[j-1];
            end
            sq_cur[j] = {in_sq_rem[j], in_sq_s[j][61-2*j -: 2]};
            sq_test[j] = {2'b00, in_sq_root[j], 2'b01};
            if (sq_cur[j] >= sq_test[j]) begin
                n_sq_rem[j] = 33'(sq_cur[j] - sq_test[j]);
                n_sq_root[j] = {in_sq_root[j][29:0], 1'b1};
            end else begin
                n_sq_rem[j] = sq_cur[j][32:0];
                n_sq_root[j] = {in_sq_root[j][29:0], 1'b0};
            end
        end
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                in_dv_v[k] = r_sq_v[SQRT_STAGES-1];
                in_dv_ctx[k] = r_sq_ctx[SQRT_STAGES-1];
                in_dv_rem[k] = r_sq_root[SQRT_STAGES-1];
                in_dv_q[k] = '0;
            end else begin
                in_dv_v[k] = r_dv_v[k-1];
                in_dv_ctx[k] = r_dv_ctx[k-1];
                in_dv_rem[k] = r_dv_rem[k-1];
                in_dv_q[k] = r_dv_q[k-1];
            end
            dv_tr[k] = {in_dv_rem[k], 1'b0};
            dv_ge[k] = dv_tr[k] >= {1'b0, i_cfg.radius};
            n_dv_rem[k] = dv_ge[k] ? 31'(dv_tr[k] - {1'b0, i_cfg.radius}) : dv_tr[k][30:0];
            n_dv_q[k] = {in_dv_q[k][14:0], dv_ge[k]};
        end
    end

    always_comb begin
        w_num = 51'(64'h0001_0000_8000_0000) + {2'b00, r_w2_t3, 1'b0}
              - ({3'b000, r_w2_t2, 16'd0} + {2'b00, r_w2_t2, 17'd0});
        unique case (i_cfg.mode)
            MODE_LINEAR:  w_raw = ONE_Q16 - {1'b0, r_w2_t};
            MODE_CONST:   w_raw = ONE_Q16;
            MODE_SMOOTH,
            MODE_INFLATE: w_raw = w_num[48:32];
            default:      w_raw = '0;
        endcase
        w_hit = r_w2_ctx.live && (w_raw > CULL_LIMIT);
        n_w3_ctx = r_w2_ctx;
        n_w3_ctx.live = w_hit;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            inf_r = r_m2_inf[i] + 66'sd536870912;
            mv_r = r_m2_mv[i] + 50'sd32768;
            if (i_cfg.mode == MODE_INFLATE) begin
                delta[i] = inf_r[64:30];
            end else begin
                delta[i] = {mv_r[49], mv_r[49:16]};
            end
            sum[i] = $signed({{3{r_m2_ctx.pos[i][31]}}, r_m2_ctx.pos[i]}) + delta[i];
            if (!r_m2_ctx.live) begin
                res[i] = r_m2_ctx.pos[i];
            end else if ($signed(sum[i]) > 35'sh0_7FFF_FFFF) begin
                res[i] = 32'h7FFF_FFFF;
            end else if ($signed(sum[i]) < -35'sh0_8000_0000) begin
                res[i] = 32'h8000_0000;
            end else begin
                res[i] = sum[i][31:0];
            end
        end
        cnt_base = r_m2_ctx.pass_start ? 17'd0 : r_cnt;
        cnt_next = (r_m2_ctx.live && (cnt_base < CNT_MAX)) ? cnt_base + 17'd1 : cnt_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SQRT_STAGES; j++) begin
                r_sq_v[j] <= 1'b0;
            end
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dv_v[k] <= 1'b0;
            end
            r_w1_v <= 1'b0;
            r_w2_v <= 1'b0;
            r_w3_v <= 1'b0;
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_ov <= 1'b0;
            r_cnt <= '0;
        end else if (en) begin
            for (int j = 0; j < SQRT_STAGES; j++) begin
                r_sq_v[j] <= in_sq_v[j];
            end
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dv_v[k] <= in_dv_v[k];
            end
            r_w1_v <= r_dv_v[DIV_STAGES-1];
            r_w2_v <= r_w1_v;
            r_w3_v <= r_w2_v;
            r_m1_v <= r_w3_v;
            r_m2_v <= r_m1_v;
            r_ov <= r_m2_v;
            if (r_m2_v) begin
                r_cnt <= cnt_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < SQRT_STAGES; j++) begin
                r_sq_ctx[j] <= in_sq_ctx[j];
                r_sq_s[j] <= in_sq_s[j];
                r_sq_rem[j] <= n_sq_rem[j];
                r_sq_root[j] <= n_sq_root[j];
            end
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dv_ctx[k] <= in_dv_ctx[k];
                r_dv_rem[k] <= n_dv_rem[k];
                r_dv_q[k] <= n_dv_q[k];
            end
            r_w1_ctx <= r_dv_ctx[DIV_STAGES-1];
            r_w1_t <= r_dv_q[DIV_STAGES-1];
            r_w1_t2 <= r_dv_q[DIV_STAGES-1] * r_dv_q[DIV_STAGES-1];
            r_w2_ctx <= r_w1_ctx;
            r_w2_t <= r_w1_t;
            r_w2_t2 <= r_w1_t2;
            r_w2_t3 <= r_w1_t2 * r_w1_t;
            r_w3_ctx <= n_w3_ctx;
            r_w3_w <= w_hit ? w_raw : 17'd0;
            r_m1_ctx <= r_w3_ctx;
            r_m1_w <= r_w3_w;
            for (int i = 0; i < 3; i++) begin
                r_m1_mv[i] <= $signed(i_cfg.offset[i]) * $signed({1'b0, r_w3_w});
            end
            r_m2_ctx <= r_m1_ctx;
            r_m2_w <= r_m1_w;
            r_m2_mv <= r_m1_mv;
            for (int i = 0; i < 3; i++) begin
                r_m2_inf[i] <= $signed(r_m1_ctx.nrm[i]) * $signed(r_m1_mv[0]);
            end
            if (r_m2_v) begin
                r_onew <= res;
                r_oaff <= r_m2_ctx.live;
                r_ow <= r_m2_w;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_new = r_onew;
    assign o_affected = r_oaff;
    assign o_weight = r_ow;
    assign o_count = r_cnt;

endmodule

>>> src/sculpt_brush_displace.sv
// Top level: configuration registers, stream ports and the front/back pipeline.
// Pipeline: 3 front stages, queue, 31 square-root stages, 16 divide stages and
// 6 weight/multiply/output stages. Throughput: one transaction per cycle while the
// queue is not full; the whole back pipeline holds while a result waits, and the
// four-entry queue lets the front keep accepting meanwhile.
// Reset clears configuration, the affected count and all valid flags.
module sculpt_brush_displace (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, rep_valid, pass_start
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_x, new_y, new_z, affected, weight, affected_count
    output logic [135:0] m_axis_tdata
);
    import sbd_pkg::*;

    t_cfg r_cfg;
    t_reg_idx widx;
    t_ctx in_ctx;
    logic push, full, pop, empty, front_ready;
    t_item f_item, q_item;
    logic [2:0][31:0] new_pos;
    logic aff;
    logic [16:0] w, cnt;

    assign pready = 1'b1;
    assign widx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (widx)
                REG_CENTER_X: r_cfg.center[0] <= pwdata;
                REG_CENTER_Y: r_cfg.center[1] <= pwdata;
                REG_CENTER_Z: r_cfg.center[2] <= pwdata;
                REG_RADIUS:   r_cfg.radius <= pwdata[30:0];
                REG_MODE:     r_cfg.mode <= t_mode'(pwdata[1:0]);
                REG_OFFSET_X: r_cfg.offset[0] <= pwdata;
                REG_OFFSET_Y: r_cfg.offset[1] <= pwdata;
                REG_OFFSET_Z: r_cfg.offset[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_CENTER_X: prdata = r_cfg.center[0];
            REG_CENTER_Y: prdata = r_cfg.center[1];
            REG_CENTER_Z: prdata = r_cfg.center[2];
            REG_RADIUS:   prdata = {1'b0, r_cfg.radius};
            REG_MODE:     prdata = {30'd0, r_cfg.mode};
            REG_OFFSET_X: prdata = r_cfg.offset[0];
            REG_OFFSET_Y: prdata = r_cfg.offset[1];
            REG_OFFSET_Z: prdata = r_cfg.offset[2];
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        in_ctx.pos[0] = s_axis_tdata[31:0];
        in_ctx.pos[1] = s_axis_tdata[63:32];
        in_ctx.pos[2] = s_axis_tdata[95:64];
        in_ctx.nrm[0] = s_axis_tdata[111:96];
        in_ctx.nrm[1] = s_axis_tdata[127:112];
        in_ctx.nrm[2] = s_axis_tdata[143:128];
        in_ctx.live = s_axis_tdata[144];
        in_ctx.pass_start = s_axis_tdata[145];
    end

    assign s_axis_tready = front_ready;

    sbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (front_ready),
        .i_ctx   (in_ctx),
        .i_full  (full),
        .o_push  (push),
        .o_item  (f_item)
    );

    sbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (q_item)
    );

    sbd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (empty),
        .i_item     (q_item),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_new      (new_pos),
        .o_affected (aff),
        .o_weight   (w),
        .o_count    (cnt)
    );

    assign m_axis_tdata = {5'd0, cnt, w, aff, new_pos[2], new_pos[1], new_pos[0]};

endmodule

>>> tb/sbd_checker.sv
// Checker for the brush displacement block: tracks registers, predicts results, compares.
module sbd_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         pready,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [151:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [135:0] m_axis_tdata,
    output int           o_fail_count,
    output int           o_pending
);
    import sbd_pkg::*;

    typedef struct packed {
        logic [31:0] new_x;
        logic [31:0] new_y;
        logic [31:0] new_z;
        logic        hit;
        logic [16:0] weight;
        logic [16:0] count;
    } t_displaced;

    logic signed [31:0] centre [3];
    logic signed [31:0] shift  [3];
    logic [30:0]        radius;
    t_mode              mode;
    logic [16:0]        hit_count;
    t_displaced         expected_q [$];
    int                 fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint round_down(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic t_displaced displace(logic [151:0] d);
        t_displaced      r;
        longint          p [3];
        longint          n [3];
        longint          dv [3];
        longint          res [3];
        longint          a, delta;
        longint unsigned s, rad, root, t, t2, t3, s48, w;
        logic            in_box;
        logic            hit;
        w = 0;
        hit = 1'b0;
        rad = longint'(radius);
        for (int i = 0; i < 3; i++) begin
            p[i]   = longint'($signed(d[32*i +: 32]));
            n[i]   = longint'($signed(d[96 + 16*i +: 16]));
            res[i] = p[i];
        end
        if (d[145]) hit_count = '0;
        if (d[144] && rad != 0) begin
            in_box = 1'b1;
            for (int i = 0; i < 3; i++) begin
                dv[i] = p[i] - longint'(centre[i]);
                a = dv[i] < 0 ? -dv[i] : dv[i];
                if (longint'(a) >= longint'(rad)) in_box = 1'b0;
            end
            if (in_box) begin
                s = 0;
                for (int i = 0; i < 3; i++) s += longint'(dv[i] * dv[i]);
                if (s < rad * rad) begin
                    root = root_floor(s);
                    t = (root << 16) / rad;
                    case (mode)
                        MODE_LINEAR: w = 65536 - t;
                        MODE_CONST:  w = 65536;
                        default: begin
                            t2  = t * t;
                            t3  = t2 * t;
                            s48 = 3 * t2 * 65536 - 2 * t3;
                            w   = ((longint'(1) << 48) - s48 + (longint'(1) << 31)) >> 32;
                        end
                    endcase
                    hit = w > longint'(CULL_LIMIT);
                end
            end
        end
        if (hit) begin
            for (int i = 0; i < 3; i++) begin
                if (mode == MODE_INFLATE)
                    delta = round_down(n[i] * longint'(shift[0]) * longint'(w), 30);
                else
                    delta = round_down(longint'(shift[i]) * longint'(w), 16);
                res[i] = p[i] + delta;
                if (res[i] > 64'sd2147483647) res[i] = 64'sd2147483647;
                if (res[i] < -64'sd2147483648) res[i] = -64'sd2147483648;
            end
            if (hit_count < CNT_MAX) hit_count = hit_count + 1'b1;
        end else begin
            w = 0;
        end
        r.new_x  = res[0][31:0];
        r.new_y  = res[1][31:0];
        r.new_z  = res[2][31:0];
        r.hit    = hit;
        r.weight = w[16:0];
        r.count  = hit_count;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_displaced got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                centre[i] = '0;
                shift[i]  = '0;
            end
            radius    = '0;
            mode      = MODE_LINEAR;
            hit_count = '0;
            expected_q.delete();
            fails     = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_CENTER_X: centre[0] = pwdata;
                    REG_CENTER_Y: centre[1] = pwdata;
                    REG_CENTER_Z: centre[2] = pwdata;
                    REG_RADIUS:   radius    = pwdata[30:0];
                    REG_MODE:     mode      = t_mode'(pwdata[1:0]);
                    REG_OFFSET_X: shift[0]  = pwdata;
                    REG_OFFSET_Y: shift[1]  = pwdata;
                    REG_OFFSET_Z: shift[2]  = pwdata;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q = {expected_q, displace(s_axis_tdata)};
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                       m_axis_tdata[96], m_axis_tdata[113:97], m_axis_tdata[130:114]};
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result transaction %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch: exp x=%h y=%h z=%h hit=%b w=%0d cnt=%0d",
                                     want.new_x, want.new_y, want.new_z, want.hit,
                                     want.weight, want.count);
                            $display("          got x=%h y=%h z=%h hit=%b w=%0d cnt=%0d",
                                     got.new_x, got.new_y, got.new_z, got.hit,
                                     got.weight, got.count);
                        end
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_sculpt_brush_displace.sv
// Testbench top for the brush displacement block: stimulus, configuration and verdict.
module tb_sculpt_brush_displace;
    import sbd_pkg::*;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    int           fail_count;
    int           pending;
    int           burst_left = 0;
    int           stall_pct = 0;
    int           stall_left = 0;
    logic [31:0]  centre [3];
    logic [30:0]  radius;

    sculpt_brush_displace i_dut (.*);

    sbd_checker i_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb_sculpt_brush_displace NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left <= $urandom_range(20, 300);
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 20;
                2: stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
        end else begin
            stall_left <= stall_left - 1;
        end
        m_axis_tready <= $urandom_range(0, 99) >= stall_pct;
    end

    task automatic reg_write(t_reg_idx idx, logic [31:0] value);
        if (idx == REG_RADIUS) radius = value[30:0];
        if (idx <= REG_CENTER_Z) centre[2'(idx)] = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic setup(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, logic [31:0] rad,
                         t_mode m, logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
        drain();
        reg_write(REG_CENTER_X, cx);
        reg_write(REG_CENTER_Y, cy);
        reg_write(REG_CENTER_Z, cz);
        reg_write(REG_RADIUS, rad);
        reg_write(REG_MODE, 32'(m));
        reg_write(REG_OFFSET_X, ox);
        reg_write(REG_OFFSET_Y, oy);
        reg_write(REG_OFFSET_Z, oz);
    endtask

    task automatic send(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                        logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                        logic valid, logic start, bit bursty);
        int gap;
        if (bursty && burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_axis_tdata  <= {6'b0, start, valid, nz, ny, nx, pz, py, px};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [31:0] near_axis(int axis);
        longint span, off;
        span = longint'(radius) * 5 / 8 + 2;
        off  = longint'($urandom_range(0, 32'(span)));
        if ($urandom_range(0, 1)) off = -off;
        return 32'(longint'($signed(centre[axis])) + off);
    endfunction

    function automatic logic [15:0] rand_normal();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic logic [31:0] rand_reg();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] rad;
        logic [31:0] px, py, pz;
        logic        valid;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: zero radius, nothing affected
        radius = '0;
        for (int i = 0; i < 3; i++) centre[i] = '0;
        send(0, 0, 0, 16'd16384, 0, 0, 1, 1, 0);
        send(32'h7FFF_FFFF, 32'h8000_0000, 1, 16'h8000, 16'h7FFF, 16'hC000, 1, 0, 0);

        setup(0, 0, 0, 32'h0001_0000, MODE_CONST, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
        send(0, 0, 0, 0, 0, 0, 1, 1, 0);
        send(32'h0001_0000, 0, 0, 0, 0, 0, 1, 0, 0);
        send(32'h0000_FFFF, 0, 0, 0, 0, 0, 1, 0, 0);
        send(32'h0000_9000, 32'h0000_9000, 32'h0000_9000, 0, 0, 0, 1, 0, 0);
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 1, 0, 0);
        send(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send(32'h0000_0100, 32'hFFFF_FF00, 0, 0, 0, 0, 1, 1, 0);

        setup(0, 0, 0, 32'h0001_0000, MODE_LINEAR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1000);
        send(0, 0, 0, 0, 0, 0, 1, 0, 0);
        send(32'h0000_FF00, 0, 0, 0, 0, 0, 1, 0, 0);
        send(32'h0000_FFC0, 0, 0, 0, 0, 0, 1, 0, 0);
        send(32'h7FFF_0000, 32'h8000_0000, 0, 0, 0, 0, 1, 0, 0);

        setup(32'h7FFF_0000, 0, 0, 32'h0010_0000, MODE_INFLATE, 32'h7FFF_FFFF, 0, 0);
        send(32'h7FFF_0000, 0, 0, 16'd16384, 16'hC000, 16'h7FFF, 1, 0, 0);
        send(32'h7FFF_0000, 32'h0008_0000, 0, 16'h8000, 16'd16384, 0, 1, 0, 0);

        setup(0, 0, 0, 32'h0010_0000, MODE_SMOOTH, 32'h0100_0000, 32'hFF00_0000, 32'h7FFF_FFFF);
        send(0, 0, 0, 0, 0, 0, 1, 0, 0);
        send(32'h0008_0000, 0, 0, 0, 0, 0, 1, 0, 0);
        send(32'h000F_F000, 0, 0, 0, 0, 0, 1, 0, 0);
        send(32'h000F_0000, 0, 0, 0, 0, 0, 1, 0, 0);

        // one pass with every transaction affected
        setup(0, 0, 0, 32'h7FFF_FFFF, MODE_CONST, 1, 32'hFFFF_FFFF, 0);
        for (int k = 0; k < 24; k++)
            send(32'($urandom_range(0, 4095)), 32'($urandom_range(0, 4095)), 0, 0, 0, 0, 1,
                 k == 0, k % 8 == 0);
        send(0, 0, 0, 0, 0, 0, 1, 1, 0);

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: rad = 32'h7FFF_FFFF;
                1: rad = 1;
                2: rad = 0;
                default: begin
                    case ($urandom_range(0, 3))
                        0: rad = $urandom_range(1, 64);
                        1: rad = $urandom_range(1, 32'h00FF_FFFF);
                        default: rad = {1'b0, 31'($urandom)};
                    endcase
                end
            endcase
            if (ph == 0)
                setup(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, rad, MODE_INFLATE,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            else if (ph == 1)
                setup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, rad, MODE_LINEAR,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            else
                setup(rand_reg(), rand_reg(), rand_reg(), rad, t_mode'($urandom_range(0, 3)),
                      rand_reg(), rand_reg(), rand_reg());
            for (int k = 0; k < 115; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    px = $urandom;
                    py = $urandom;
                    pz = $urandom;
                end else begin
                    px = near_axis(0);
                    py = near_axis(1);
                    pz = near_axis(2);
                end
                valid = $urandom_range(0, 9) != 0;
                send(px, py, pz, rand_normal(), rand_normal(), rand_normal(), valid,
                     $urandom_range(0, 19) == 0, 1);
            end
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_sculpt_brush_displace OK");
        else
            $display("tb_sculpt_brush_displace NOT OK");
        $finish;
    end

endmodule
